// ===== src/tct_pkg.sv =====
// Shared constants, types and helpers of the teletype text console.
package tct_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int MEMORY_CELLS   = 8192;

  localparam int AW       = 13;
  localparam int CW       = 14;
  localparam int COLW     = $clog2(SCREEN_COLUMNS + 1);
  localparam int ROWW     = $clog2(SCREEN_ROWS);
  localparam int SCR      = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int KEEP     = SCR - SCREEN_COLUMNS;
  localparam int MAXRES   = 5;
  localparam int KW       = 3;
  localparam int QDEPTH   = 2;

  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_HT  = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DEL = 8'h7F;

  typedef enum logic [2:0] {
    ACT_WRITE  = 3'd0,
    ACT_FILL   = 3'd1,
    ACT_COPY   = 3'd2,
    ACT_START  = 3'd3,
    ACT_CURSOR = 3'd4
  } action_t;

  typedef struct packed {
    action_t         action;
    logic [AW-1:0]   cell_address;
    logic [AW-1:0]   source_address;
    logic [CW-1:0]   cell_count;
    logic [15:0]     cell_value;
  } res_t;

  typedef struct packed {
    res_t [MAXRES-1:0] res;
    logic [KW-1:0]     count;
  } bundle_t;

  function automatic res_t mk_res(action_t act, logic [AW-1:0] addr,
                                  logic [AW-1:0] src, logic [CW-1:0] cnt,
                                  logic [15:0] val);
    res_t r;
    r.action         = act;
    r.cell_address   = addr;
    r.source_address = src;
    r.cell_count     = cnt;
    r.cell_value     = val;
    return r;
  endfunction

endpackage

// ===== src/tct_if.sv =====
// Handshake channels for input items and result items.
interface tct_item_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_code;
  logic       end_of_buffer;

  modport source(output valid, command, char_code, end_of_buffer, input ready);
  modport sink(input valid, command, char_code, end_of_buffer, output ready);
endinterface

interface tct_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [12:0] cell_address;
  logic [12:0] source_address;
  logic [13:0] cell_count;
  logic [15:0] cell_value;
  logic        last_result;

  modport source(output valid, action, cell_address, source_address, cell_count,
                 cell_value, last_result, input ready);
  modport sink(input valid, action, cell_address, source_address, cell_count,
               cell_value, last_result, output ready);
endinterface

// ===== src/tct_front.sv =====
// Front end: accepts items, tracks cursor and screen state, builds result bundles.
module tct_front (
  input  logic                 clk,
  input  logic                 rst,
  tct_item_if.sink             items,
  input  logic [7:0]           attr,
  input  logic                 q_full,
  output logic                 push,
  output tct_pkg::bundle_t     bundle
);

  logic [tct_pkg::AW-1:0]   start, start_next;
  logic [tct_pkg::AW-1:0]   cursor, cursor_next;
  logic [tct_pkg::COLW-1:0] col, col_next;
  logic [tct_pkg::ROWW-1:0] row, row_next;
  logic                     fire;
  logic [15:0]              blank;
  logic                     printable;
  logic                     do_lf;
  logic [tct_pkg::AW-1:0]   lf_cell;
  logic [tct_pkg::AW+1:0]   scroll_end;
  logic                     scroll_fwd;

  assign fire       = items.valid && items.ready;
  assign items.ready = !q_full;
  assign blank      = {attr, tct_pkg::BLANK_CHAR};
  assign scroll_end = {2'b00, start} + (tct_pkg::AW+2)'(tct_pkg::SCR + tct_pkg::SCREEN_COLUMNS);
  assign scroll_fwd = scroll_end < (tct_pkg::AW+2)'(tct_pkg::MEMORY_CELLS);

  always_comb begin
    printable = 1'b1;
    unique case (items.char_code)
      tct_pkg::CH_NUL, tct_pkg::CH_BEL, tct_pkg::CH_HT, tct_pkg::CH_VT,
      tct_pkg::CH_BS, tct_pkg::CH_LF, tct_pkg::CH_FF, tct_pkg::CH_CR,
      tct_pkg::CH_DEL: printable = 1'b0;
      default: printable = 1'b1;
    endcase
  end

  always_comb begin
    logic [tct_pkg::KW-1:0] k;
    logic                   wrap;
    k           = '0;
    bundle      = '0;
    start_next  = start;
    cursor_next = cursor;
    col_next    = col;
    row_next    = row;
    wrap        = col >= tct_pkg::COLW'(tct_pkg::SCREEN_COLUMNS);
    do_lf       = 1'b0;
    lf_cell     = cursor;
    if (items.command) begin
      start_next  = '0;
      cursor_next = '0;
      col_next    = '0;
      row_next    = '0;
      bundle.res[0] = tct_pkg::mk_res(tct_pkg::ACT_CURSOR, '0, '0, '0, '0);
      bundle.res[1] = tct_pkg::mk_res(tct_pkg::ACT_START, '0, '0, '0, '0);
      bundle.res[2] = tct_pkg::mk_res(tct_pkg::ACT_FILL, '0, '0,
                                      tct_pkg::CW'(tct_pkg::MEMORY_CELLS), blank);
      k = tct_pkg::KW'(3);
    end else begin
      // Optional wrap to the next line ahead of a printable byte.
      if (printable && wrap) begin
        col_next = col - tct_pkg::COLW'(tct_pkg::SCREEN_COLUMNS);
        lf_cell  = cursor - tct_pkg::AW'(tct_pkg::SCREEN_COLUMNS);
        do_lf    = 1'b1;
      end
      if (items.char_code == tct_pkg::CH_LF || items.char_code == tct_pkg::CH_FF) begin
        do_lf = 1'b1;
      end
      if (do_lf) begin
        if (row < tct_pkg::ROWW'(tct_pkg::SCREEN_ROWS - 1)) begin
          row_next    = row + 1'b1;
          cursor_next = lf_cell + tct_pkg::AW'(tct_pkg::SCREEN_COLUMNS);
        end else if (scroll_fwd) begin
          bundle.res[k] = tct_pkg::mk_res(tct_pkg::ACT_FILL,
                                          start + tct_pkg::AW'(tct_pkg::SCR), '0,
                                          tct_pkg::CW'(tct_pkg::SCREEN_COLUMNS), blank);
          k = k + 1'b1;
          start_next  = start + tct_pkg::AW'(tct_pkg::SCREEN_COLUMNS);
          cursor_next = lf_cell + tct_pkg::AW'(tct_pkg::SCREEN_COLUMNS);
          bundle.res[k] = tct_pkg::mk_res(tct_pkg::ACT_START, start_next, '0, '0, '0);
          k = k + 1'b1;
        end else begin
          bundle.res[k] = tct_pkg::mk_res(tct_pkg::ACT_COPY, '0,
                                          start + tct_pkg::AW'(tct_pkg::SCREEN_COLUMNS),
                                          tct_pkg::CW'(tct_pkg::KEEP), '0);
          k = k + 1'b1;
          bundle.res[k] = tct_pkg::mk_res(tct_pkg::ACT_FILL, tct_pkg::AW'(tct_pkg::KEEP),
                                          '0, tct_pkg::CW'(tct_pkg::SCREEN_COLUMNS), blank);
          k = k + 1'b1;
          start_next  = '0;
          cursor_next = lf_cell - start;
          bundle.res[k] = tct_pkg::mk_res(tct_pkg::ACT_START, '0, '0, '0, '0);
          k = k + 1'b1;
        end
      end
      unique case (items.char_code)
        tct_pkg::CH_NUL, tct_pkg::CH_BEL, tct_pkg::CH_HT, tct_pkg::CH_VT,
        tct_pkg::CH_FF: begin
        end
        tct_pkg::CH_BS: begin
          if (col != '0) begin
            col_next    = col - 1'b1;
            cursor_next = cursor - 1'b1;
            bundle.res[k] = tct_pkg::mk_res(tct_pkg::ACT_FILL, cursor_next, '0,
                                            tct_pkg::CW'(1), blank);
            k = k + 1'b1;
          end
        end
        tct_pkg::CH_LF: begin
          cursor_next = cursor_next - tct_pkg::AW'(col);
          col_next    = '0;
        end
        tct_pkg::CH_CR: begin
          cursor_next = cursor - tct_pkg::AW'(col);
          col_next    = '0;
        end
        tct_pkg::CH_DEL: begin
          bundle.res[k] = tct_pkg::mk_res(tct_pkg::ACT_FILL, cursor, '0,
                                          tct_pkg::CW'(1), blank);
          k = k + 1'b1;
        end
        default: begin
          if (!wrap) begin
            cursor_next = cursor;
          end
          bundle.res[k] = tct_pkg::mk_res(tct_pkg::ACT_WRITE, cursor_next, '0,
                                          tct_pkg::CW'(1), {attr, items.char_code});
          k = k + 1'b1;
          cursor_next = cursor_next + 1'b1;
          col_next    = col_next + 1'b1;
        end
      endcase
      if (items.end_of_buffer) begin
        bundle.res[k] = tct_pkg::mk_res(tct_pkg::ACT_CURSOR, cursor_next, '0, '0, '0);
        k = k + 1'b1;
      end
    end
    bundle.count = k;
  end

  assign push = fire && (bundle.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      start  <= '0;
      cursor <= '0;
      col    <= '0;
      row    <= '0;
    end else if (fire) begin
      start  <= start_next;
      cursor <= cursor_next;
      col    <= col_next;
      row    <= row_next;
    end
  end

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= tct_pkg::COLW'(tct_pkg::SCREEN_COLUMNS))
    else $error("column beyond pending wrap position");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row < tct_pkg::ROWW'(tct_pkg::SCREEN_ROWS))
    else $error("row beyond last screen row");
`endif

endmodule

// ===== src/tct_queue.sv =====
// Short queue of result bundles between the front end and the back end.
module tct_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tct_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output tct_pkg::bundle_t head
);

  localparam int PW = $clog2(tct_pkg::QDEPTH);

  tct_pkg::bundle_t mem [tct_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      fill;

  assign full      = fill == (PW+1)'(tct_pkg::QDEPTH);
  assign not_empty = fill != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !pop)
    else $error("pop from an empty queue");
`endif

endmodule

// ===== src/tct_back.sv =====
// Back end: holds one result bundle and sends its results one per cycle while the output is ready.
module tct_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  tct_pkg::bundle_t q_head,
  output logic             pop,
  tct_result_if.source     results
);

  tct_pkg::bundle_t       cur;
  logic                   cur_valid;
  logic [tct_pkg::KW-1:0] idx;
  logic                   last;
  logic                   out_fire;
  tct_pkg::res_t          r;

  assign r        = cur.res[idx];
  assign last     = idx == (cur.count - 1'b1);
  assign out_fire = results.valid && results.ready;
  assign pop      = q_not_empty && (!cur_valid || (out_fire && last));

  assign results.valid          = cur_valid;
  assign results.action         = r.action;
  assign results.cell_address   = r.cell_address;
  assign results.source_address = r.source_address;
  assign results.cell_count     = r.cell_count;
  assign results.cell_value     = r.cell_value;
  assign results.last_result    = last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (out_fire) begin
      if (last) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx < cur.count))
    else $error("result index past the bundle length");
`endif

endmodule

// ===== src/text_console_teletype.sv =====
// Top level of the teletype text console.
// An item's bundle is queued, then loaded into the idle back end that offers its results.
// Items are accepted back to back while the two-entry bundle queue has room.
// Results leave one per cycle while the output is ready; clear gives three results and a
// scroll up to five, and the output sets the sustained rate.
// Synchronous reset homes the cursor, zeroes the start, sets attribute 7, empties the queue.
module text_console_teletype (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write_en,
  input  logic [7:0]   cfg_write_data,
  tct_item_if.sink     items,
  tct_result_if.source results
);

  logic [7:0]       attr;
  logic             push;
  logic             q_full;
  logic             pop;
  logic             q_not_empty;
  tct_pkg::bundle_t push_data;
  tct_pkg::bundle_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tct_pkg::ATTR_RESET;
    end else if (cfg_write_en) begin
      attr <= cfg_write_data;
    end
  end

  tct_front u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .attr   (attr),
    .q_full (q_full),
    .push   (push),
    .bundle (push_data)
  );

  tct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  tct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .results     (results)
  );

endmodule

// ===== tb/text_console_teletype_tb.sv =====
// Self-checking testbench for the teletype text console.
`timescale 1ns / 1ps

module text_console_teletype_tb;

  typedef struct {
    tct_pkg::action_t action;
    logic [12:0]      addr;
    logic [12:0]      src;
    logic [13:0]      count;
    logic [15:0]      value;
    bit               last;
  } cell_op_t;

  logic       clk;
  logic       rst;
  logic       cfg_write_en;
  logic [7:0] cfg_write_data;

  tct_item_if   item_ch();
  tct_result_if result_ch();

  text_console_teletype uut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .items(item_ch),
    .results(result_ch)
  );

  logic [7:0]  attr;
  logic [12:0] scr_start;
  logic [12:0] cur_cell;
  logic [6:0]  cur_col;
  logic [4:0]  cur_row;

  cell_op_t item_ops[$];
  cell_op_t pending_ops[$];
  cell_op_t want;

  int errors;
  int items_sent;
  int results_seen;
  int base_copies;
  int fills_forward;
  int idle_pct;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("text_console_teletype verification failed");
    $finish;
  end

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                results_seen, name, got, exp_val));
    end
  endtask

  function automatic logic [15:0] blank_value();
    return {attr, tct_pkg::BLANK_CHAR};
  endfunction

  function automatic void add_op(tct_pkg::action_t a, int addr, int src, int cnt, int val);
    cell_op_t op;
    op.action = a;
    op.addr   = addr[12:0];
    op.src    = src[12:0];
    op.count  = cnt[13:0];
    op.value  = val[15:0];
    op.last   = 1'b0;
    item_ops.push_back(op);
  endfunction

  function automatic void scroll_screen();
    if (int'(scr_start) + tct_pkg::SCR + tct_pkg::SCREEN_COLUMNS < tct_pkg::MEMORY_CELLS) begin
      add_op(tct_pkg::ACT_FILL, int'(scr_start) + tct_pkg::SCR, 0,
             tct_pkg::SCREEN_COLUMNS, int'(blank_value()));
      scr_start = 13'(int'(scr_start) + tct_pkg::SCREEN_COLUMNS);
      cur_cell  = 13'(int'(cur_cell) + tct_pkg::SCREEN_COLUMNS);
      fills_forward++;
    end else begin
      add_op(tct_pkg::ACT_COPY, 0, int'(scr_start) + tct_pkg::SCREEN_COLUMNS,
             tct_pkg::KEEP, 0);
      add_op(tct_pkg::ACT_FILL, tct_pkg::KEEP, 0, tct_pkg::SCREEN_COLUMNS,
             int'(blank_value()));
      cur_cell  = cur_cell - scr_start;
      scr_start = '0;
      base_copies++;
    end
    add_op(tct_pkg::ACT_START, int'(scr_start), 0, 0, 0);
  endfunction

  function automatic void line_feed();
    if (int'(cur_row) + 1 < tct_pkg::SCREEN_ROWS) begin
      cur_row  = cur_row + 1'b1;
      cur_cell = 13'(int'(cur_cell) + tct_pkg::SCREEN_COLUMNS);
    end else begin
      scroll_screen();
    end
  endfunction

  function automatic void carriage_return();
    cur_cell = cur_cell - 13'(cur_col);
    cur_col  = '0;
  endfunction

  // Works out the commands that one accepted item causes and queues them.
  function automatic void console_predict(bit cmd, logic [7:0] ch, bit eob);
    item_ops.delete();
    if (cmd) begin
      scr_start = '0;
      cur_cell  = '0;
      cur_col   = '0;
      cur_row   = '0;
      add_op(tct_pkg::ACT_CURSOR, 0, 0, 0, 0);
      add_op(tct_pkg::ACT_START, 0, 0, 0, 0);
      add_op(tct_pkg::ACT_FILL, 0, 0, tct_pkg::MEMORY_CELLS, int'(blank_value()));
    end else begin
      case (ch)
        tct_pkg::CH_NUL, tct_pkg::CH_BEL, tct_pkg::CH_HT, tct_pkg::CH_VT: begin
        end
        tct_pkg::CH_BS: begin
          if (cur_col != '0) begin
            cur_col  = cur_col - 1'b1;
            cur_cell = cur_cell - 1'b1;
            add_op(tct_pkg::ACT_FILL, int'(cur_cell), 0, 1, int'(blank_value()));
          end
        end
        tct_pkg::CH_LF: begin
          line_feed();
          carriage_return();
        end
        tct_pkg::CH_FF: begin
          line_feed();
        end
        tct_pkg::CH_CR: begin
          carriage_return();
        end
        tct_pkg::CH_DEL: begin
          add_op(tct_pkg::ACT_FILL, int'(cur_cell), 0, 1, int'(blank_value()));
        end
        default: begin
          if (int'(cur_col) >= tct_pkg::SCREEN_COLUMNS) begin
            cur_col  = 7'(int'(cur_col) - tct_pkg::SCREEN_COLUMNS);
            cur_cell = 13'(int'(cur_cell) - tct_pkg::SCREEN_COLUMNS);
            line_feed();
          end
          add_op(tct_pkg::ACT_WRITE, int'(cur_cell), 0, 1, int'({attr, ch}));
          cur_cell = cur_cell + 1'b1;
          cur_col  = cur_col + 1'b1;
        end
      endcase
      if (eob) begin
        add_op(tct_pkg::ACT_CURSOR, int'(cur_cell), 0, 0, 0);
      end
    end
    if (item_ops.size() > 0) begin
      item_ops[item_ops.size() - 1].last = 1'b1;
    end
    foreach (item_ops[i]) begin
      pending_ops.push_back(item_ops[i]);
    end
  endfunction

  function automatic bit is_control(logic [7:0] c);
    return c inside {tct_pkg::CH_NUL, tct_pkg::CH_BEL, tct_pkg::CH_BS, tct_pkg::CH_HT,
                     tct_pkg::CH_LF, tct_pkg::CH_VT, tct_pkg::CH_FF, tct_pkg::CH_CR,
                     tct_pkg::CH_DEL};
  endfunction

  function automatic logic [7:0] random_glyph();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (is_control(c)) begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  task automatic send_item(bit cmd, logic [7:0] ch, bit eob);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) begin
        @(negedge clk);
      end
    end
    item_ch.valid         = 1'b1;
    item_ch.command       = cmd;
    item_ch.char_code     = ch;
    item_ch.end_of_buffer = eob;
    do begin
      @(posedge clk);
    end while (!item_ch.ready);
    console_predict(cmd, ch, eob);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (pending_ops.size() > 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    drain_results();
    @(negedge clk);
    cfg_write_en   = 1'b1;
    cfg_write_data = value;
    attr           = value;
    @(negedge clk);
    cfg_write_en   = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_ops.size() == 0) begin
        report_mismatch($sformatf("unexpected result, action %0d address 0x%0h",
                                  result_ch.action, result_ch.cell_address));
      end else begin
        want = pending_ops.pop_front();
        check_field("action", 16'(result_ch.action), 16'(want.action));
        check_field("cell_address", 16'(result_ch.cell_address), 16'(want.addr));
        check_field("source_address", 16'(result_ch.source_address), 16'(want.src));
        check_field("cell_count", 16'(result_ch.cell_count), 16'(want.count));
        check_field("cell_value", result_ch.cell_value, want.value);
        check_field("last_result", 16'(result_ch.last_result), 16'(want.last));
      end
      results_seen++;
    end
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic test_controls();
    send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 8'h41, 1'b0);
    send_item(1'b0, 8'hFF, 1'b1);
    send_item(1'b0, tct_pkg::CH_NUL, 1'b0);
    send_item(1'b0, tct_pkg::CH_BEL, 1'b1);
    send_item(1'b0, tct_pkg::CH_HT, 1'b0);
    send_item(1'b0, tct_pkg::CH_VT, 1'b1);
    send_item(1'b0, tct_pkg::CH_BS, 1'b0);
    send_item(1'b0, tct_pkg::CH_DEL, 1'b1);
    send_item(1'b0, tct_pkg::CH_CR, 1'b0);
    send_item(1'b0, tct_pkg::CH_BS, 1'b1);
    send_item(1'b0, 8'h20, 1'b0);
    send_item(1'b1, 8'h00, 1'b1);
  endtask

  // Line feeds until the next one would have to copy the screen back to the base.
  task automatic test_scroll();
    int n;
    n = 0;
    while ((int'(cur_row) + 1 < tct_pkg::SCREEN_ROWS ||
            int'(scr_start) + tct_pkg::SCR + tct_pkg::SCREEN_COLUMNS < tct_pkg::MEMORY_CELLS)
           && n < 120) begin
      send_item(1'b0, ($urandom_range(3) == 0) ? tct_pkg::CH_FF : tct_pkg::CH_LF,
                $urandom_range(3) == 0);
      n++;
    end
  endtask

  // A full line, a pending wrap, and a wrap that copies the screen back to the base.
  task automatic test_line_wrap();
    repeat (tct_pkg::SCREEN_COLUMNS) begin
      send_item(1'b0, random_glyph(), $urandom_range(7) == 0);
    end
    send_item(1'b0, tct_pkg::CH_DEL, 1'b1);
    send_item(1'b0, tct_pkg::CH_BS, 1'b0);
    send_item(1'b0, random_glyph(), 1'b0);
    send_item(1'b0, random_glyph(), 1'b1);
    send_item(1'b0, tct_pkg::CH_LF, 1'b1);
  endtask

  initial begin
    rst                   = 1'b1;
    cfg_write_en          = 1'b0;
    cfg_write_data        = 8'h00;
    item_ch.valid         = 1'b0;
    item_ch.command       = 1'b0;
    item_ch.char_code     = 8'h00;
    item_ch.end_of_buffer = 1'b0;
    attr                  = tct_pkg::ATTR_RESET;
    scr_start             = '0;
    cur_cell              = '0;
    cur_col               = '0;
    cur_row               = '0;
    errors                = 0;
    items_sent            = 0;
    results_seen          = 0;
    base_copies           = 0;
    fills_forward         = 0;
    idle_pct              = 21;
    stall_pct             = 21;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_controls();

    write_attribute(8'($urandom_range(255)));
    test_scroll();

    write_attribute(8'hFF);
    idle_pct  = 0;
    stall_pct = 0;
    test_line_wrap();
    idle_pct  = 21;
    stall_pct = 21;

    drain_results();
    $display("Summary: %0d items sent, %0d results checked, %0d mismatches.",
             items_sent, results_seen, errors);
    $display("Scrolling: %0d forward fills, %0d copies back to the memory base.",
             fills_forward, base_copies);
    if (errors == 0) begin
      $display("text_console_teletype verification clean");
    end else begin
      $display("text_console_teletype verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tct_pkg.sv
src/tct_if.sv
src/tct_front.sv
src/tct_queue.sv
src/tct_back.sv
src/text_console_teletype.sv
tb/text_console_teletype_tb.sv
